// File: rtl/core/zid_pkg.sv
// Shared types and constants for the Z80 instruction decoder.
package zid_pkg;

  typedef logic [6:0] cls_t;

  // Prefix and page-select opcode bytes
  localparam logic [7:0] PFX_DD = 8'hDD;
  localparam logic [7:0] PFX_FD = 8'hFD;
  localparam logic [7:0] PFX_CB = 8'hCB;
  localparam logic [7:0] PFX_ED = 8'hED;

  localparam logic [2:0] Z_MEM  = 3'b110;
  localparam logic [2:0] Y_MEM  = 3'b110;

  typedef enum logic [1:0] {
    PAGE_MAIN  = 2'd0,
    PAGE_CB    = 2'd1,
    PAGE_ED    = 2'd2,
    PAGE_IDXCB = 2'd3
  } page_e;

  typedef enum logic [1:0] {
    IDX_HL = 2'd0,
    IDX_IX = 2'd1,
    IDX_IY = 2'd2
  } idx_e;

  // Operation classes
  localparam cls_t CLS_NOP      = 7'd0;
  localparam cls_t CLS_EX_AF    = 7'd1;
  localparam cls_t CLS_DJNZ     = 7'd2;
  localparam cls_t CLS_JR       = 7'd3;
  localparam cls_t CLS_JR_CC    = 7'd4;
  localparam cls_t CLS_LD_RR_NN = 7'd5;
  localparam cls_t CLS_ADD_IX   = 7'd6;
  localparam cls_t CLS_ADD_IY   = 7'd7;
  localparam cls_t CLS_ADD_HL   = 7'd8;
  localparam cls_t CLS_ST_A_RR  = 7'd9;
  localparam cls_t CLS_ST_NN_RR = 7'd10;
  localparam cls_t CLS_ST_NN_A  = 7'd11;
  localparam cls_t CLS_LD_A_RR  = 7'd12;
  localparam cls_t CLS_LD_RR_MN = 7'd13;
  localparam cls_t CLS_LD_A_NN  = 7'd14;
  localparam cls_t CLS_INC_RR   = 7'd15;
  localparam cls_t CLS_DEC_RR   = 7'd16;
  localparam cls_t CLS_INC_R    = 7'd17;
  localparam cls_t CLS_DEC_R    = 7'd18;
  localparam cls_t CLS_LD_R_N   = 7'd19;
  localparam cls_t CLS_RLCA     = 7'd20;
  localparam cls_t CLS_HALT     = 7'd28;
  localparam cls_t CLS_LD_R_R   = 7'd29;
  localparam cls_t CLS_ALU_R    = 7'd30;
  localparam cls_t CLS_RET      = 7'd31;
  localparam cls_t CLS_POP      = 7'd32;
  localparam cls_t CLS_EXX      = 7'd33;
  localparam cls_t CLS_JP_RR    = 7'd34;
  localparam cls_t CLS_LD_SP    = 7'd35;
  localparam cls_t CLS_JP_CC    = 7'd36;
  localparam cls_t CLS_JP       = 7'd37;
  localparam cls_t CLS_OUT_N    = 7'd38;
  localparam cls_t CLS_IN_N     = 7'd39;
  localparam cls_t CLS_EX_SP_IX = 7'd40;
  localparam cls_t CLS_EX_SP_IY = 7'd41;
  localparam cls_t CLS_EX_SP_HL = 7'd42;
  localparam cls_t CLS_EX_DE_HL = 7'd43;
  localparam cls_t CLS_DI       = 7'd44;
  localparam cls_t CLS_EI       = 7'd45;
  localparam cls_t CLS_CALL_CC  = 7'd46;
  localparam cls_t CLS_PUSH     = 7'd47;
  localparam cls_t CLS_CALL     = 7'd48;
  localparam cls_t CLS_ALU_N    = 7'd49;
  localparam cls_t CLS_RST      = 7'd50;
  localparam cls_t CLS_ROT      = 7'd51;
  localparam cls_t CLS_BIT      = 7'd52;
  localparam cls_t CLS_RES      = 7'd53;
  localparam cls_t CLS_SET      = 7'd54;
  localparam cls_t CLS_IN_RC    = 7'd55;
  localparam cls_t CLS_IN_C     = 7'd56;
  localparam cls_t CLS_OUT_CR   = 7'd57;
  localparam cls_t CLS_OUT_C0   = 7'd58;
  localparam cls_t CLS_SBC_HL   = 7'd59;
  localparam cls_t CLS_ADC_HL   = 7'd60;
  localparam cls_t CLS_NEG      = 7'd61;
  localparam cls_t CLS_RETN     = 7'd62;
  localparam cls_t CLS_RETI     = 7'd63;
  localparam cls_t CLS_IM       = 7'd64;
  localparam cls_t CLS_RRD      = 7'd65;
  localparam cls_t CLS_RLD      = 7'd66;
  localparam cls_t CLS_BLOCK    = 7'd67;
  localparam cls_t CLS_UNDEF    = 7'd68;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } win_t;

  typedef struct packed {
    cls_t              op_class;
    page_e             page;
    idx_e              index_sel;
    logic [1:0]        field_x;
    logic [2:0]        field_y;
    logic [2:0]        field_z;
    logic [1:0]        field_p;
    logic              field_q;
    logic              indexed_memory;
    logic signed [7:0] displacement;
    logic [1:0]        prefix_bytes;
  } res_t;

endpackage

// File: rtl/core/zid_if.sv
// Handshake interfaces for the fetch window and decode result channels.
interface zid_win_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2, input byte3,
                  output ready);
endinterface

interface zid_res_if;
  logic              valid;
  logic              ready;
  logic [6:0]        op_class;
  logic [1:0]        page;
  logic [1:0]        index_sel;
  logic [1:0]        field_x;
  logic [2:0]        field_y;
  logic [2:0]        field_z;
  logic [1:0]        field_p;
  logic              field_q;
  logic              indexed_memory;
  logic signed [7:0] displacement;
  logic [1:0]        prefix_bytes;

  modport source (output valid, output op_class, output page, output index_sel,
                  output field_x, output field_y, output field_z, output field_p,
                  output field_q, output indexed_memory, output displacement,
                  output prefix_bytes, input ready);
  modport sink   (input valid, input op_class, input page, input index_sel,
                  input field_x, input field_y, input field_z, input field_p,
                  input field_q, input indexed_memory, input displacement,
                  input prefix_bytes, output ready);
endinterface

// File: rtl/core/zid_decode.sv
// Combinational decode of one four-byte fetch window.
module zid_decode
  import zid_pkg::*;
(
  input  win_t win_i,
  output res_t res_o
);

  function automatic cls_t main_class(input logic [7:0] op, input idx_e ix);
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    cls_t       c;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    p = op[5:4];
    q = op[3];
    c = CLS_UNDEF;
    unique case (x)
      2'd0: begin
        unique case (z)
          3'd0: c = (y < 3'd4) ? cls_t'(y) : CLS_JR_CC;
          3'd1: begin
            if (!q) c = CLS_LD_RR_NN;
            else if (ix == IDX_IX) c = CLS_ADD_IX;
            else if (ix == IDX_IY) c = CLS_ADD_IY;
            else c = CLS_ADD_HL;
          end
          3'd2: begin
            if (!q) c = (p < 2'd2) ? CLS_ST_A_RR : ((p == 2'd2) ? CLS_ST_NN_RR : CLS_ST_NN_A);
            else c = (p < 2'd2) ? CLS_LD_A_RR : ((p == 2'd2) ? CLS_LD_RR_MN : CLS_LD_A_NN);
          end
          3'd3: c = q ? CLS_DEC_RR : CLS_INC_RR;
          3'd4: c = CLS_INC_R;
          3'd5: c = CLS_DEC_R;
          3'd6: c = CLS_LD_R_N;
          default: c = CLS_RLCA + cls_t'(y);
        endcase
      end
      2'd1: c = (y == Y_MEM && z == Z_MEM) ? CLS_HALT : CLS_LD_R_R;
      2'd2: c = CLS_ALU_R;
      default: begin
        unique case (z)
          3'd0: c = CLS_RET;
          3'd1: begin
            if (!q) c = CLS_POP;
            else begin
              unique case (p)
                2'd0: c = CLS_RET;
                2'd1: c = CLS_EXX;
                2'd2: c = CLS_JP_RR;
                default: c = CLS_LD_SP;
              endcase
            end
          end
          3'd2: c = CLS_JP_CC;
          3'd3: begin
            unique case (y)
              3'd0: c = CLS_JP;
              3'd2: c = CLS_OUT_N;
              3'd3: c = CLS_IN_N;
              3'd4: begin
                if (ix == IDX_IX) c = CLS_EX_SP_IX;
                else if (ix == IDX_IY) c = CLS_EX_SP_IY;
                else c = CLS_EX_SP_HL;
              end
              3'd5: c = CLS_EX_DE_HL;
              3'd6: c = CLS_DI;
              3'd7: c = CLS_EI;
              default: c = CLS_UNDEF;  // CB page select
            endcase
          end
          3'd4: c = CLS_CALL_CC;
          3'd5: begin
            if (!q) c = CLS_PUSH;
            else c = (p == 2'd0) ? CLS_CALL : CLS_UNDEF;
          end
          3'd6: c = CLS_ALU_N;
          default: c = CLS_RST;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic cls_t ed_class(input logic [7:0] op);
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    cls_t       c;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    c = CLS_UNDEF;
    if (x == 2'd1) begin
      unique case (z)
        3'd0: c = (y != 3'd6) ? CLS_IN_RC : CLS_IN_C;
        3'd1: c = (y != 3'd6) ? CLS_OUT_CR : CLS_OUT_C0;
        3'd2: c = op[3] ? CLS_ADC_HL : CLS_SBC_HL;
        3'd3: c = op[3] ? CLS_LD_RR_MN : CLS_ST_NN_RR;
        3'd4: c = CLS_NEG;
        3'd5: c = (y == 3'd1) ? CLS_RETI : CLS_RETN;
        3'd6: c = CLS_IM;
        default: begin
          if (y < 3'd4) c = CLS_LD_R_R;
          else if (y == 3'd4) c = CLS_RRD;
          else if (y == 3'd5) c = CLS_RLD;
          else c = CLS_NOP;
        end
      endcase
    end else if (x == 2'd2 && z <= 3'd3 && y >= 3'd4) begin
      c = CLS_BLOCK;
    end
    return c;
  endfunction

  function automatic cls_t bit_class(input logic [1:0] x);
    return CLS_ROT + cls_t'(x);
  endfunction

  logic       is_idx;
  logic [7:0] op;
  cls_t       cls;
  page_e      page;
  idx_e       ix;
  logic [1:0] pre;
  logic       mem;
  logic [7:0] disp;

  assign is_idx = (win_i.byte0 == PFX_DD) || (win_i.byte0 == PFX_FD);

  always_comb begin
    op   = win_i.byte0;
    cls  = CLS_UNDEF;
    page = PAGE_MAIN;
    ix   = IDX_HL;
    pre  = 2'd0;
    mem  = 1'b0;
    disp = 8'd0;
    if (is_idx) begin
      ix  = (win_i.byte0 == PFX_DD) ? IDX_IX : IDX_IY;
      pre = 2'd1;
      op  = win_i.byte1;
      if (win_i.byte1 == PFX_DD || win_i.byte1 == PFX_FD) begin
        cls = CLS_UNDEF;
      end else if (win_i.byte1 == PFX_ED) begin
        // index prefix has no effect on the ED page
        ix   = IDX_HL;
        page = PAGE_ED;
        pre  = 2'd2;
        op   = win_i.byte2;
        cls  = ed_class(win_i.byte2);
      end else if (win_i.byte1 == PFX_CB) begin
        page = PAGE_IDXCB;
        pre  = 2'd3;
        op   = win_i.byte3;
        mem  = 1'b1;
        disp = win_i.byte2;
        cls  = (win_i.byte3[7:6] == 2'd1 || win_i.byte3[2:0] == Z_MEM)
               ? bit_class(win_i.byte3[7:6]) : CLS_UNDEF;
      end else begin
        cls = main_class(win_i.byte1, ix);
        // (HL) operand slots: INC/DEC/LD (HL), LD with one (HL) side, ALU (HL)
        if ((win_i.byte1[7:6] == 2'd0 && win_i.byte1[5:3] == Y_MEM &&
             win_i.byte1[2:0] >= 3'd4 && win_i.byte1[2:0] <= 3'd6) ||
            (win_i.byte1[7:6] == 2'd1 &&
             ((win_i.byte1[5:3] == Y_MEM) != (win_i.byte1[2:0] == Z_MEM))) ||
            (win_i.byte1[7:6] == 2'd2 && win_i.byte1[2:0] == Z_MEM)) begin
          mem  = 1'b1;
          disp = win_i.byte2;
        end
      end
    end else if (win_i.byte0 == PFX_CB) begin
      page = PAGE_CB;
      pre  = 2'd1;
      op   = win_i.byte1;
      cls  = bit_class(win_i.byte1[7:6]);
    end else if (win_i.byte0 == PFX_ED) begin
      page = PAGE_ED;
      pre  = 2'd1;
      op   = win_i.byte1;
      cls  = ed_class(win_i.byte1);
    end else begin
      cls = main_class(win_i.byte0, IDX_HL);
    end
  end

  always_comb begin
    res_o.op_class       = cls;
    res_o.page           = page;
    res_o.index_sel      = ix;
    res_o.field_x        = op[7:6];
    res_o.field_y        = op[5:3];
    res_o.field_z        = op[2:0];
    res_o.field_p        = op[5:4];
    res_o.field_q        = op[3];
    res_o.indexed_memory = mem;
    res_o.displacement   = $signed(disp);
    res_o.prefix_bytes   = pre;
  end

endmodule

// File: rtl/core/z80_instruction_decoder.sv
// Top level: registered Z80 instruction decoder with window and result channels.
//
//   channel  dir  modport          payload
//   win_i    in   zid_win_if.sink  byte0..byte3 fetch window
//   res_o    out  zid_res_if.source op_class, page, index_sel, fields, disp, prefix count
//
// Datapath: window register, decode logic, result register.
// One transaction per cycle while res_o.ready is high; both stages advance together.
// rst_ni clears both stage valid bits asynchronously; payload is not reset.
// A stalled result holds the result register; the window stage holds behind
// it and win_i.ready drops only when both stages are full.
module z80_instruction_decoder
  import zid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  zid_win_if.sink          win_i,
  zid_res_if.source        res_o
);

  win_t win_q;
  logic in_v_q;
  res_t res_q;
  res_t res_d;
  logic out_v_q;
  logic out_load;
  logic in_ready;
  logic win_acc;

  assign out_load = !out_v_q || res_o.ready;
  assign in_ready = !in_v_q || out_load;
  assign win_acc  = win_i.valid && in_ready;

  assign win_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (win_acc) begin
      in_v_q <= 1'b1;
    end else if (out_load) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_acc) begin
      win_q <= '{byte0: win_i.byte0, byte1: win_i.byte1,
                 byte2: win_i.byte2, byte3: win_i.byte3};
    end
  end

  zid_decode u_decode (
    .win_i (win_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_v_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.op_class       = res_q.op_class;
  assign res_o.page           = res_q.page;
  assign res_o.index_sel      = res_q.index_sel;
  assign res_o.field_x        = res_q.field_x;
  assign res_o.field_y        = res_q.field_y;
  assign res_o.field_z        = res_q.field_z;
  assign res_o.field_p        = res_q.field_p;
  assign res_o.field_q        = res_q.field_q;
  assign res_o.indexed_memory = res_q.indexed_memory;
  assign res_o.displacement   = res_q.displacement;
  assign res_o.prefix_bytes   = res_q.prefix_bytes;

  // window stage must hold while the result stage is blocked
  a_win_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !out_load |=> in_v_q && $stable(win_q))
    else $error("window stage lost while result stalled");

  // a decoded window reaches the result register
  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && out_load |=> out_v_q)
    else $error("decoded transaction dropped");

  // displacement is only meaningful for indexed memory operands
  a_disp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_q.indexed_memory |-> res_q.displacement == 8'sd0)
    else $error("nonzero displacement without indexed memory");

  // indexed CB page always consumes three prefix bytes and is indexed
  a_idxcb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.page == PAGE_IDXCB |->
      res_q.prefix_bytes == 2'd3 && res_q.indexed_memory && res_q.index_sel != IDX_HL)
    else $error("indexed CB result inconsistent");

  // ED page never reports an index register
  a_ed_noidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.page == PAGE_ED |-> res_q.index_sel == IDX_HL && !res_q.indexed_memory)
    else $error("ED page result carries index select");

endmodule
